FILE: design/peuq_pkg.sv
// ----------------------------------------------------------------------------
// Particle Euler update package
// Shared types, attribute codes, constants and saturating arithmetic.
// ----------------------------------------------------------------------------
package peuq_pkg;

  localparam int PARTICLE_SLOTS_DEF = 1024;
  localparam int FRACTION_BITS_DEF  = 16;

  localparam int CORDIC_STEPS   = 24;
  // Fold stage, one stage per rotation, negate stage.
  localparam int CORDIC_LATENCY = CORDIC_STEPS + 2;

  localparam logic [19:0] ETERNAL_LIFE = 20'd999999;
  localparam logic [19:0] LIFE_CEIL    = 20'hFFFFF;
  localparam logic signed [31:0] LIFE_CEIL_WORD = 32'sd1048575;

  localparam logic signed [31:0] RAD_TO_TURN  = 32'sd683565276;
  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

  localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
  localparam logic signed [39:0] SAT_LO = -40'sd2147483648;

  typedef logic signed [31:0] word_t;

  typedef enum logic [4:0] {
    ATTR_LIFE = 5'd0, ATTR_TRAIL, ATTR_X, ATTR_Y, ATTR_XV, ATTR_YV, ATTR_XA, ATTR_YA,
    ATTR_DIR, ATTR_DIRV, ATTR_DIRA, ATTR_VEL, ATTR_VELV, ATTR_VELA,
    ATTR_SIZE, ATTR_SIZEV, ATTR_SIZEA,
    ATTR_R, ATTR_RV, ATTR_RA, ATTR_G, ATTR_GV, ATTR_GA,
    ATTR_B, ATTR_BV, ATTR_BA, ATTR_A, ATTR_AV, ATTR_AA
  } attr_e;

  // Row read at the front of the pipeline: life, trail and the steering terms.
  typedef struct packed {
    logic [19:0] life;
    logic        trail;
    word_t       dir;
    word_t       dirv;
    word_t       dira;
    word_t       vel;
    word_t       velv;
    word_t       vela;
  } drec_t;

  // Row read at the update stage: position, size, colour and old position.
  typedef struct packed {
    word_t       x;
    word_t       y;
    word_t       xv;
    word_t       yv;
    word_t       xa;
    word_t       ya;
    word_t       size;
    word_t       sizev;
    word_t       sizea;
    word_t [3:0] col;
    word_t [3:0] colv;
    word_t [3:0] cola;
    word_t       ox;
    word_t       oy;
  } urec_t;

  // Rotation angles in 2^-32 turns.
  function automatic word_t turn_angle(input int k);
    word_t r;
    case (k)
      0:       r = 32'sd536870912;
      1:       r = 32'sd316933406;
      2:       r = 32'sd167458907;
      3:       r = 32'sd85004756;
      4:       r = 32'sd42667331;
      5:       r = 32'sd21354465;
      6:       r = 32'sd10679838;
      7:       r = 32'sd5340245;
      8:       r = 32'sd2670163;
      9:       r = 32'sd1335087;
      10:      r = 32'sd667544;
      11:      r = 32'sd333772;
      12:      r = 32'sd166886;
      13:      r = 32'sd83443;
      14:      r = 32'sd41722;
      15:      r = 32'sd20861;
      16:      r = 32'sd10430;
      17:      r = 32'sd5215;
      18:      r = 32'sd2608;
      19:      r = 32'sd1304;
      20:      r = 32'sd652;
      21:      r = 32'sd326;
      22:      r = 32'sd163;
      23:      r = 32'sd81;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic word_t sat40(input logic signed [39:0] v);
    word_t r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    return sat40(40'(a) + 40'(b));
  endfunction

endpackage

FILE: design/peuq_in_if.sv
// ----------------------------------------------------------------------------
// Particle command channel
// Valid/ready channel carrying one write or step command.
// ----------------------------------------------------------------------------
interface peuq_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [9:0]         particle_slot;
  logic [4:0]         attribute_select;
  logic signed [31:0] write_value;

  modport source (output valid, cmd, particle_slot, attribute_select, write_value,
                  input ready);
  modport sink (input valid, cmd, particle_slot, attribute_select, write_value,
                output ready);
endinterface

FILE: design/peuq_out_if.sv
// ----------------------------------------------------------------------------
// Particle quad channel
// Valid/ready channel carrying one quad and its colour.
// ----------------------------------------------------------------------------
interface peuq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] corner0_x;
  logic signed [31:0] corner0_y;
  logic signed [31:0] corner1_x;
  logic signed [31:0] corner1_y;
  logic signed [31:0] corner2_x;
  logic signed [31:0] corner2_y;
  logic signed [31:0] corner3_x;
  logic signed [31:0] corner3_y;
  logic signed [31:0] red_out;
  logic signed [31:0] green_out;
  logic signed [31:0] blue_out;
  logic signed [31:0] alpha_out;

  modport source (output valid, corner0_x, corner0_y, corner1_x, corner1_y,
                  corner2_x, corner2_y, corner3_x, corner3_y,
                  red_out, green_out, blue_out, alpha_out,
                  input ready);
  modport sink (input valid, corner0_x, corner0_y, corner1_x, corner1_y,
                corner2_x, corner2_y, corner3_x, corner3_y,
                red_out, green_out, blue_out, alpha_out,
                output ready);
endinterface

FILE: design/peuq_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC
// Cosine and sine in Q30 of a 32-bit turn phase, one rotation per stage.
// ----------------------------------------------------------------------------
module peuq_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase,
  output logic signed [33:0] cos_q,
  output logic signed [33:0] sin_q
);

  localparam int N = peuq_pkg::CORDIC_STEPS;

  logic signed [32:0] xs [N+1];
  logic signed [32:0] ys [N+1];
  logic signed [32:0] zs [N+1];
  logic               neg [N+1];

  logic [31:0] ph_rot;
  logic        fold;
  logic [31:0] ph_fold;

  // Phases in the half turn around pi are rotated by half a turn.
  assign ph_rot  = phase + 32'h4000_0000;
  assign fold    = ph_rot[31];
  assign ph_fold = {phase[31] ^ fold, phase[30:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]  <= peuq_pkg::CORDIC_START;
      ys[0]  <= '0;
      zs[0]  <= 33'($signed(ph_fold));
      neg[0] <= fold;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        neg[k+1] <= neg[k];
        if (!zs[k][32]) begin
          xs[k+1] <= xs[k] - (ys[k] >>> k);
          ys[k+1] <= ys[k] + (xs[k] >>> k);
          zs[k+1] <= zs[k] - 33'(peuq_pkg::turn_angle(k));
        end else begin
          xs[k+1] <= xs[k] + (ys[k] >>> k);
          ys[k+1] <= ys[k] - (xs[k] >>> k);
          zs[k+1] <= zs[k] + 33'(peuq_pkg::turn_angle(k));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= neg[N] ? -34'(xs[N]) : 34'(xs[N]);
      sin_q <= neg[N] ? -34'(ys[N]) : 34'(ys[N]);
    end
  end

endmodule

FILE: design/particle_euler_update_quads.sv
// ----------------------------------------------------------------------------
// Particle Euler update with quad output
// Particle table, one slot stepped or written per transaction.
// ----------------------------------------------------------------------------
// The block takes one command per clock while ready is high and returns a quad
// after each step of a live slot.
// Each slot lives in two row memories: life, trail and the steering terms are
// read and rewritten right after the input register, and position, size and
// colour are read and rewritten after the pipelined CORDIC and velocity
// multiply. Each row memory is read and written once per cycle at one stage,
// with a one-row bypass, so back-to-back steps of the same slot are exact.
// After reset the life/trail memory is cleared one row per cycle with ready
// held low. The pipeline stalls only when a result is waiting at the output
// and another result is right behind it.
module particle_euler_update_quads #(
  parameter int PARTICLE_SLOTS = peuq_pkg::PARTICLE_SLOTS_DEF,
  parameter int FRACTION_BITS  = peuq_pkg::FRACTION_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  peuq_in_if.sink    in,
  peuq_out_if.source out
);

  localparam int AW  = (PARTICLE_SLOTS > 1) ? $clog2(PARTICLE_SLOTS) : 1;
  localparam int CL  = peuq_pkg::CORDIC_LATENCY;
  localparam int UST = CL + 2;

  typedef logic [AW-1:0] addr_t;

  typedef struct packed {
    logic            valid;
    logic            step;
    logic            alive;
    logic            trail;
    logic [4:0]      sel;
    peuq_pkg::word_t val;
    addr_t           addr;
    peuq_pkg::word_t vel;
  } side_t;

  logic  adv;
  logic  clr_active;
  addr_t clr_idx;
  logic  in_range;

  // Front stage and its row memory.
  side_t           s1;
  peuq_pkg::drec_t d_mem [PARTICLE_SLOTS];
  peuq_pkg::drec_t d_rdata;
  peuq_pkg::drec_t d_cur;
  peuq_pkg::drec_t d_new;
  peuq_pkg::drec_t d_fwd_row;
  logic            d_fwd_v;
  addr_t           d_fwd_addr;
  addr_t           d_raddr;
  logic            d_we_item;
  logic            d_we;
  logic            d_alive;

  side_t              sb [UST+1];
  peuq_pkg::word_t    dir_s;
  logic signed [63:0] dir_prod;
  logic [31:0]        phase_s;
  logic signed [33:0] cos_q;
  logic signed [33:0] sin_q;
  logic signed [65:0] px;
  logic signed [65:0] py;
  logic signed [35:0] dx;
  logic signed [35:0] dy;

  // Update stage and its row memory.
  peuq_pkg::urec_t u_mem [PARTICLE_SLOTS];
  peuq_pkg::urec_t u_rdata;
  peuq_pkg::urec_t u_cur;
  peuq_pkg::urec_t u_new;
  peuq_pkg::urec_t u_fwd_row;
  logic            u_fwd_v;
  addr_t           u_fwd_addr;
  addr_t           u_raddr;
  logic            u_we_item;
  logic            u_we;
  logic            u_emit;
  peuq_pkg::word_t x1;
  peuq_pkg::word_t y1;

  logic            q1_valid;
  peuq_pkg::urec_t q1_rec;
  logic            q1_trail;

  logic signed [33:0] dqx;
  logic signed [33:0] dqy;
  logic [33:0]        mqx;
  logic [33:0]        mqy;
  logic [34:0]        wqx;
  logic [34:0]        wqy;
  logic signed [34:0] xq_c;
  logic signed [34:0] yq_c;

  logic                  q2_valid;
  logic signed [34:0]    q2_xq;
  logic signed [34:0]    q2_yq;
  peuq_pkg::word_t       q2_size;
  peuq_pkg::word_t       q2_ox;
  peuq_pkg::word_t       q2_oy;
  logic                  q2_trail;
  logic                  q2_lx;
  logic                  q2_ly;
  peuq_pkg::word_t [3:0] q2_col;

  peuq_pkg::word_t v [8];

  assign adv      = !(out.valid && !out.ready && q2_valid);
  assign in.ready = adv && !clr_active;
  assign in_range = 32'(in.particle_slot) < 32'(PARTICLE_SLOTS);

  // Clearing pass of the life/trail memory after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_active) begin
      if (clr_idx == addr_t'(PARTICLE_SLOTS - 1)) begin
        clr_active <= 1'b0;
      end else begin
        clr_idx <= clr_idx + addr_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (adv) begin
      s1.valid <= in.valid && in.ready && in_range;
      s1.step  <= in.cmd;
      s1.alive <= 1'b0;
      s1.trail <= 1'b0;
      s1.sel   <= in.attribute_select;
      s1.val   <= in.write_value;
      s1.addr  <= addr_t'(in.particle_slot);
      s1.vel   <= '0;
    end
  end

  // ---------------------------------------------------------------- front row
  assign d_raddr = adv ? addr_t'(in.particle_slot) : s1.addr;
  assign d_we    = adv && s1.valid && d_we_item;

  always_comb begin
    d_cur     = (d_fwd_v && d_fwd_addr == s1.addr) ? d_fwd_row : d_rdata;
    d_new     = d_cur;
    d_we_item = 1'b0;
    d_alive   = d_cur.life != '0;
    if (s1.step) begin
      if (d_alive) begin
        d_we_item = 1'b1;
        if (d_cur.life != peuq_pkg::ETERNAL_LIFE) begin
          d_new.life = d_cur.life - 20'd1;
        end
        d_new.dir  = peuq_pkg::sat_add(d_cur.dir, d_cur.dirv);
        d_new.dirv = peuq_pkg::sat_add(d_cur.dirv, d_cur.dira);
        d_new.vel  = peuq_pkg::sat_add(d_cur.vel, d_cur.velv);
        d_new.velv = peuq_pkg::sat_add(d_cur.velv, d_cur.vela);
      end
    end else begin
      case (s1.sel)
        peuq_pkg::ATTR_LIFE: begin
          d_we_item = 1'b1;
          if (s1.val < 0) begin
            d_new.life = '0;
          end else if (s1.val > peuq_pkg::LIFE_CEIL_WORD) begin
            d_new.life = peuq_pkg::LIFE_CEIL;
          end else begin
            d_new.life = s1.val[19:0];
          end
        end
        peuq_pkg::ATTR_TRAIL: begin
          d_we_item   = 1'b1;
          d_new.trail = s1.val != 0;
        end
        peuq_pkg::ATTR_DIR: begin
          d_we_item = 1'b1;
          d_new.dir = s1.val;
        end
        peuq_pkg::ATTR_DIRV: begin
          d_we_item  = 1'b1;
          d_new.dirv = s1.val;
        end
        peuq_pkg::ATTR_DIRA: begin
          d_we_item  = 1'b1;
          d_new.dira = s1.val;
        end
        peuq_pkg::ATTR_VEL: begin
          d_we_item = 1'b1;
          d_new.vel = s1.val;
        end
        peuq_pkg::ATTR_VELV: begin
          d_we_item  = 1'b1;
          d_new.velv = s1.val;
        end
        peuq_pkg::ATTR_VELA: begin
          d_we_item  = 1'b1;
          d_new.vela = s1.val;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      d_mem[clr_idx] <= '0;
    end else if (d_we) begin
      d_mem[s1.addr] <= d_new;
    end
    d_rdata <= d_mem[d_raddr];
  end

  // The row read for the next transaction misses the write on the same edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_fwd_v <= 1'b0;
    end else if (adv) begin
      d_fwd_v    <= d_we;
      d_fwd_row  <= d_new;
      d_fwd_addr <= s1.addr;
    end
  end

  // ---------------------------------------------------------------- sideband
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= UST; i++) begin
        sb[i].valid <= 1'b0;
      end
    end else if (adv) begin
      sb[0] <= '{valid: s1.valid, step: s1.step, alive: d_alive, trail: d_cur.trail,
                 sel: s1.sel, val: s1.val, addr: s1.addr, vel: d_cur.vel};
      for (int i = 1; i <= UST; i++) begin
        sb[i] <= sb[i-1];
      end
    end
  end

  assign dir_prod = dir_s * peuq_pkg::RAD_TO_TURN;
  assign px       = sb[CL+1].vel * cos_q;
  assign py       = sb[CL+1].vel * sin_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      dir_s   <= d_cur.dir;
      phase_s <= dir_prod[FRACTION_BITS +: 32];
      dx      <= px[65:30];
      dy      <= py[65:30];
    end
  end

  peuq_cordic u_cordic (
    .clk   (clk),
    .en    (adv),
    .phase (phase_s),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  // ---------------------------------------------------------------- update row
  assign u_raddr = adv ? sb[UST-1].addr : sb[UST].addr;
  assign u_we    = adv && sb[UST].valid && u_we_item;
  assign u_emit  = sb[UST].step && sb[UST].alive;

  always_comb begin
    u_cur     = (u_fwd_v && u_fwd_addr == sb[UST].addr) ? u_fwd_row : u_rdata;
    u_new     = u_cur;
    u_we_item = 1'b0;
    x1        = peuq_pkg::sat_add(u_cur.x, u_cur.xv);
    y1        = peuq_pkg::sat_add(u_cur.y, u_cur.yv);
    if (sb[UST].step) begin
      if (sb[UST].alive) begin
        u_we_item   = 1'b1;
        u_new.ox    = u_cur.x;
        u_new.oy    = u_cur.y;
        u_new.x     = peuq_pkg::sat40(40'(x1) + 40'(dx));
        u_new.y     = peuq_pkg::sat40(40'(y1) + 40'(dy));
        u_new.size  = peuq_pkg::sat_add(u_cur.size, u_cur.sizev);
        u_new.sizev = peuq_pkg::sat_add(u_cur.sizev, u_cur.sizea);
        u_new.xv    = peuq_pkg::sat_add(u_cur.xv, u_cur.xa);
        u_new.yv    = peuq_pkg::sat_add(u_cur.yv, u_cur.ya);
        for (int c = 0; c < 4; c++) begin
          u_new.col[c]  = peuq_pkg::sat_add(u_cur.col[c], u_cur.colv[c]);
          u_new.colv[c] = peuq_pkg::sat_add(u_cur.colv[c], u_cur.cola[c]);
        end
      end
    end else begin
      case (sb[UST].sel)
        peuq_pkg::ATTR_X: begin
          u_we_item = 1'b1;
          u_new.x   = sb[UST].val;
          u_new.ox  = sb[UST].val;
        end
        peuq_pkg::ATTR_Y: begin
          u_we_item = 1'b1;
          u_new.y   = sb[UST].val;
          u_new.oy  = sb[UST].val;
        end
        peuq_pkg::ATTR_XV: begin
          u_we_item = 1'b1;
          u_new.xv  = sb[UST].val;
        end
        peuq_pkg::ATTR_YV: begin
          u_we_item = 1'b1;
          u_new.yv  = sb[UST].val;
        end
        peuq_pkg::ATTR_XA: begin
          u_we_item = 1'b1;
          u_new.xa  = sb[UST].val;
        end
        peuq_pkg::ATTR_YA: begin
          u_we_item = 1'b1;
          u_new.ya  = sb[UST].val;
        end
        peuq_pkg::ATTR_SIZE: begin
          u_we_item  = 1'b1;
          u_new.size = sb[UST].val;
        end
        peuq_pkg::ATTR_SIZEV: begin
          u_we_item   = 1'b1;
          u_new.sizev = sb[UST].val;
        end
        peuq_pkg::ATTR_SIZEA: begin
          u_we_item   = 1'b1;
          u_new.sizea = sb[UST].val;
        end
        default: begin
          // Colour terms come in triples: value, rate, acceleration.
          for (int c = 0; c < 4; c++) begin
            if (sb[UST].sel == 5'(int'(peuq_pkg::ATTR_R) + 3 * c)) begin
              u_we_item    = 1'b1;
              u_new.col[c] = sb[UST].val;
            end
            if (sb[UST].sel == 5'(int'(peuq_pkg::ATTR_RV) + 3 * c)) begin
              u_we_item     = 1'b1;
              u_new.colv[c] = sb[UST].val;
            end
            if (sb[UST].sel == 5'(int'(peuq_pkg::ATTR_RA) + 3 * c)) begin
              u_we_item     = 1'b1;
              u_new.cola[c] = sb[UST].val;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (u_we) begin
      u_mem[sb[UST].addr] <= u_new;
    end
    u_rdata <= u_mem[u_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_fwd_v <= 1'b0;
    end else if (adv) begin
      u_fwd_v    <= u_we;
      u_fwd_row  <= u_new;
      u_fwd_addr <= sb[UST].addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_valid <= 1'b0;
    end else if (adv) begin
      q1_valid <= sb[UST].valid && u_emit;
      q1_rec   <= u_new;
      q1_trail <= sb[UST].trail;
    end
  end

  // ---------------------------------------------------------------- quad
  // Without a trail the corner is x - size/2 rounded toward zero to a whole.
  always_comb begin
    dqx = $signed({q1_rec.x[31], q1_rec.x, 1'b0}) - 34'(q1_rec.size);
    dqy = $signed({q1_rec.y[31], q1_rec.y, 1'b0}) - 34'(q1_rec.size);
    mqx = dqx[33] ? 34'(-dqx) : 34'(dqx);
    mqy = dqy[33] ? 34'(-dqy) : 34'(dqy);
    wqx = 35'(mqx >> (FRACTION_BITS + 1));
    wqy = 35'(mqy >> (FRACTION_BITS + 1));
    wqx = wqx << FRACTION_BITS;
    wqy = wqy << FRACTION_BITS;
    if (q1_trail) begin
      xq_c = 35'(q1_rec.x);
      yq_c = 35'(q1_rec.y);
    end else begin
      xq_c = dqx[33] ? -$signed(wqx) : $signed(wqx);
      yq_c = dqy[33] ? -$signed(wqy) : $signed(wqy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q2_valid <= 1'b0;
    end else if (adv) begin
      q2_valid <= q1_valid;
      q2_xq    <= xq_c;
      q2_yq    <= yq_c;
      q2_size  <= q1_rec.size;
      q2_ox    <= q1_rec.ox;
      q2_oy    <= q1_rec.oy;
      q2_trail <= q1_trail;
      q2_lx    <= q1_rec.ox <= q1_rec.x;
      q2_ly    <= q1_rec.oy <= q1_rec.y;
      q2_col   <= q1_rec.col;
    end
  end

  // With a trail, the corner facing back along the movement takes the old
  // position.
  always_comb begin
    v[0] = peuq_pkg::sat40(40'(q2_xq));
    v[1] = peuq_pkg::sat40(40'(q2_yq));
    v[2] = peuq_pkg::sat40(40'(q2_xq) + 40'(q2_size));
    v[3] = peuq_pkg::sat40(40'(q2_yq));
    v[4] = peuq_pkg::sat40(40'(q2_xq) + 40'(q2_size));
    v[5] = peuq_pkg::sat40(40'(q2_yq) + 40'(q2_size));
    v[6] = peuq_pkg::sat40(40'(q2_xq));
    v[7] = peuq_pkg::sat40(40'(q2_yq) + 40'(q2_size));
    if (q2_trail) begin
      if (q2_lx && q2_ly) begin
        v[0] = q2_ox;
        v[1] = q2_oy;
      end else if (q2_lx) begin
        v[6] = q2_ox;
        v[7] = peuq_pkg::sat_add(q2_size, q2_oy);
      end else if (q2_ly) begin
        v[2] = peuq_pkg::sat_add(q2_size, q2_ox);
        v[3] = q2_oy;
      end else begin
        v[4] = peuq_pkg::sat_add(q2_size, q2_ox);
        v[5] = peuq_pkg::sat_add(q2_size, q2_oy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (!out.valid || out.ready) begin
      out.valid     <= q2_valid;
      out.corner0_x <= v[0];
      out.corner0_y <= v[1];
      out.corner1_x <= v[2];
      out.corner1_y <= v[3];
      out.corner2_x <= v[4];
      out.corner2_y <= v[5];
      out.corner3_x <= v[6];
      out.corner3_y <= v[7];
      out.red_out   <= q2_col[0];
      out.green_out <= q2_col[1];
      out.blue_out  <= q2_col[2];
      out.alpha_out <= q2_col[3];
    end
  end

  // ---------------------------------------------------------------- checks
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> (!out.valid && !q2_valid && !sb[UST].valid && !s1.valid))
    else $error("pipeline holds work during the clearing pass");

  a_emit_reaches_quad: assert property (@(posedge clk) disable iff (rst)
    (adv && sb[UST].valid && u_emit) |=> q1_valid)
    else $error("live step lost after the update stage");

  a_clear_full: assert property (@(posedge clk) disable iff (rst)
    $fell(clr_active) |-> $past(clr_idx) == addr_t'(PARTICLE_SLOTS - 1))
    else $error("clearing pass ended early");

endmodule

FILE: dv/peuq_scoreboard.sv
// ----------------------------------------------------------------------------
// Particle quad scoreboard
// Watches both channels, advances its own particle table for every accepted
// command, and compares each quad transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module peuq_scoreboard (
  input  logic clk,
  input  logic rst,
  peuq_in_if   in_ch,
  peuq_out_if  out_ch,
  output int   errors,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import peuq_pkg::*;

  localparam int SLOTS   = PARTICLE_SLOTS_DEF;
  localparam int FRAC    = FRACTION_BITS_DEF;
  localparam int OX_WORD = 29;
  localparam int OY_WORD = 30;

  typedef logic [11:0][31:0] quad_t;

  word_t       attr [SLOTS][32];
  logic [19:0] life [SLOTS];
  logic        trail [SLOTS];
  quad_t       quad_q [$];

  function automatic word_t clamp(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return word_t'(v);
  endfunction

  function automatic void bump(input int s, input int k, input int r);
    attr[s][k] = clamp(longint'(attr[s][k]) + longint'(attr[s][r]));
  endfunction

  task automatic cos_sin(input word_t dir, output longint c, output longint s);
    longint prod, x, y, z, xs, ys;
    logic [31:0] phase;
    bit neg;
    prod = longint'(dir) * longint'(RAD_TO_TURN);
    phase = 32'(prod >> FRAC);
    neg = 0;
    // The half turn around pi is folded back and the result negated.
    if (((phase + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      phase = phase - 32'h8000_0000;
      neg = 1;
    end
    z = longint'($signed(phase));
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(turn_angle(i));
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(turn_angle(i));
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  function automatic longint corner_origin(input word_t pos, input word_t size);
    longint d, whole;
    d = 2 * longint'(pos) - longint'(size);
    if (d < 0) whole = -((-d) >> (FRAC + 1));
    else whole = d >> (FRAC + 1);
    return whole * (64'sd1 << FRAC);
  endfunction

  // Applies one command to the table; sets emits to 1 when a quad is due.
  task automatic advance_particle(input logic cmd, input int s, input int sel,
                                  input word_t val, output bit emits,
                                  output quad_t q);
    longint cq, sq, sz, x, y, ox, oy;
    word_t v [12];
    emits = 0;
    q = '0;
    if (cmd == 1'b0) begin
      if (sel == ATTR_LIFE) begin
        if (val < 0) life[s] = '0;
        else if (val > LIFE_CEIL_WORD) life[s] = LIFE_CEIL;
        else life[s] = val[19:0];
      end else if (sel == ATTR_TRAIL) begin
        trail[s] = (val != 0);
      end else if (sel <= ATTR_AA) begin
        attr[s][sel] = val;
        if (sel == ATTR_X) attr[s][OX_WORD] = val;
        if (sel == ATTR_Y) attr[s][OY_WORD] = val;
      end
      return;
    end
    if (life[s] == '0) return;
    if (life[s] != ETERNAL_LIFE) life[s] = life[s] - 1'b1;
    attr[s][OX_WORD] = attr[s][ATTR_X];
    attr[s][OY_WORD] = attr[s][ATTR_Y];
    bump(s, ATTR_X, ATTR_XV);
    bump(s, ATTR_Y, ATTR_YV);
    if (attr[s][ATTR_VEL] != 0) begin
      cos_sin(attr[s][ATTR_DIR], cq, sq);
      attr[s][ATTR_X] = clamp(longint'(attr[s][ATTR_X]) +
                              ((longint'(attr[s][ATTR_VEL]) * cq) >>> 30));
      attr[s][ATTR_Y] = clamp(longint'(attr[s][ATTR_Y]) +
                              ((longint'(attr[s][ATTR_VEL]) * sq) >>> 30));
    end
    bump(s, ATTR_DIR, ATTR_DIRV);
    bump(s, ATTR_VEL, ATTR_VELV);
    for (int c = 0; c < 4; c++) bump(s, ATTR_R + 3 * c, ATTR_R + 3 * c + 1);
    bump(s, ATTR_SIZE, ATTR_SIZEV);
    bump(s, ATTR_XV, ATTR_XA);
    bump(s, ATTR_YV, ATTR_YA);
    bump(s, ATTR_DIRV, ATTR_DIRA);
    bump(s, ATTR_VELV, ATTR_VELA);
    for (int c = 0; c < 4; c++) bump(s, ATTR_R + 3 * c + 1, ATTR_R + 3 * c + 2);
    bump(s, ATTR_SIZEV, ATTR_SIZEA);

    sz = attr[s][ATTR_SIZE];
    x = attr[s][ATTR_X];
    y = attr[s][ATTR_Y];
    if (!trail[s]) begin
      x = corner_origin(attr[s][ATTR_X], attr[s][ATTR_SIZE]);
      y = corner_origin(attr[s][ATTR_Y], attr[s][ATTR_SIZE]);
    end
    v[0] = clamp(x);      v[1] = clamp(y);
    v[2] = clamp(sz + x); v[3] = clamp(y);
    v[4] = clamp(sz + x); v[5] = clamp(sz + y);
    v[6] = clamp(x);      v[7] = clamp(sz + y);
    if (trail[s]) begin
      // The corner facing back along the movement takes the old position.
      ox = attr[s][OX_WORD];
      oy = attr[s][OY_WORD];
      if (ox <= x && oy <= y) begin
        v[0] = clamp(ox); v[1] = clamp(oy);
      end else if (ox <= x) begin
        v[6] = clamp(ox); v[7] = clamp(sz + oy);
      end else if (oy <= y) begin
        v[2] = clamp(sz + ox); v[3] = clamp(oy);
      end else begin
        v[4] = clamp(sz + ox); v[5] = clamp(sz + oy);
      end
    end
    v[8] = attr[s][ATTR_R];
    v[9] = attr[s][ATTR_G];
    v[10] = attr[s][ATTR_B];
    v[11] = attr[s][ATTR_A];
    for (int c = 0; c < 12; c++) q[c] = v[c];
    emits = 1;
  endtask

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  initial begin
    errors = 0;
    outstanding = 0;
    for (int s = 0; s < SLOTS; s++) begin
      life[s] = '0;
      trail[s] = 1'b0;
      for (int k = 0; k < 32; k++) attr[s][k] = '0;
    end
  end

  always @(posedge clk) begin
    bit    emits;
    quad_t q, got, want;
    string names [12];
    names = '{"corner0_x", "corner0_y", "corner1_x", "corner1_y",
              "corner2_x", "corner2_y", "corner3_x", "corner3_y",
              "red_out", "green_out", "blue_out", "alpha_out"};
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        advance_particle(in_ch.cmd, int'(in_ch.particle_slot),
                         int'(in_ch.attribute_select), in_ch.write_value,
                         emits, q);
        if (emits) quad_q.push_back(q);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.alpha_out, out_ch.blue_out, out_ch.green_out, out_ch.red_out,
               out_ch.corner3_y, out_ch.corner3_x, out_ch.corner2_y, out_ch.corner2_x,
               out_ch.corner1_y, out_ch.corner1_x, out_ch.corner0_y, out_ch.corner0_x};
        if (quad_q.size() == 0) begin
          report("quad transaction with no prediction pending");
        end else begin
          want = quad_q.pop_front();
          for (int c = 0; c < 12; c++) begin
            if (got[c] !== want[c]) begin
              report($sformatf("%s got %h expected %h", names[c], got[c], want[c]));
            end
          end
        end
      end
    end
    outstanding = quad_q.size();
  end
endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Particle Euler update testbench
// Loads particle records, steps them under random idling on both channels,
// and gives the verdict from the scoreboard's mismatch count and a stall watchdog.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import peuq_pkg::*;

  localparam int ITEM_TARGET = 1100;
  localparam int STALL_LIMIT = 20000;
  localparam int POOL        = 8;

  logic clk;
  logic rst;
  int   errors;
  int   outstanding;
  int   sent;
  int   idle_cycles;
  bit   quiet;
  int   pool [POOL];

  peuq_in_if  in_ch ();
  peuq_out_if out_ch ();

  particle_euler_update_quads dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch)
  );

  peuq_scoreboard scoreboard (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(input logic c, input int slot, input int sel, input word_t val);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.particle_slot <= slot[9:0];
    in_ch.attribute_select <= sel[4:0];
    in_ch.write_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    if (!quiet && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic word_t rnd_val();
    case ($urandom_range(3))
      0:       return word_t'($urandom);
      1, 2:    return word_t'($urandom_range(32'h8_0000)) - 32'sh4_0000;
      default: return word_t'($urandom_range(32'h200)) - 32'sh100;
    endcase
  endfunction

  function automatic word_t rnd_life();
    case ($urandom_range(4))
      0:       return 32'(ETERNAL_LIFE);
      1:       return word_t'($urandom);
      2:       return -word_t'($urandom_range(1, 50));
      default: return word_t'($urandom_range(1, 30));
    endcase
  endfunction

  // Writes every record word from x to the last colour term, then the trail flag; life is not written here.
  task automatic load_slot(input int slot);
    for (int sel = ATTR_X; sel <= ATTR_AA; sel++) send(1'b0, slot, sel, rnd_val());
    send(1'b0, slot, ATTR_TRAIL, $urandom_range(1) ? word_t'($urandom) : 32'sd0);
  endtask

  initial begin
    int  r;
    bit  paused;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= 1'b0;
    in_ch.particle_slot <= '0;
    in_ch.attribute_select <= '0;
    in_ch.write_value <= '0;
    rst <= 1'b1;
    quiet = 0;
    paused = 0;
    sent = 0;
    pool[0] = 0;
    for (int k = 1; k < POOL - 1; k++) pool[k] = k * 127 + $urandom_range(1, 120);
    pool[POOL - 1] = 1023;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < POOL; k++) load_slot(pool[k]);

    // Directed part: dead slots, life clamping, saturation, trail, unused selectors.
    send(1'b1, 5, ATTR_LIFE, 32'sd0);
    send(1'b0, pool[0], ATTR_LIFE, -32'sd5);
    send(1'b1, pool[0], ATTR_LIFE, 32'sd0);
    send(1'b0, pool[0], ATTR_LIFE, 32'sh7FFF_FFFF);
    send(1'b1, pool[0], ATTR_LIFE, 32'sd0);
    send(1'b0, pool[1], ATTR_X, 32'sh7FFF_FFFF);
    send(1'b0, pool[1], ATTR_XV, 32'sh7FFF_FFFF);
    send(1'b0, pool[1], ATTR_LIFE, 32'(ETERNAL_LIFE));
    send(1'b1, pool[1], ATTR_LIFE, 32'sd0);
    send(1'b1, pool[1], ATTR_LIFE, 32'sd0);
    send(1'b0, pool[1], ATTR_X, 32'sh8000_0000);
    send(1'b0, pool[1], ATTR_XV, 32'sh8000_0000);
    send(1'b1, pool[1], ATTR_LIFE, 32'sd0);
    send(1'b0, pool[2], ATTR_TRAIL, 32'sh8000_0000);
    send(1'b0, pool[2], ATTR_LIFE, 32'sd3);
    repeat (4) send(1'b1, pool[2], ATTR_LIFE, 32'sd0);
    send(1'b0, pool[3], ATTR_VEL, 32'sd0);
    send(1'b0, pool[3], ATTR_LIFE, 32'sd1);
    send(1'b1, pool[3], ATTR_LIFE, 32'sd0);
    send(1'b0, pool[4], 29, word_t'($urandom));
    send(1'b0, pool[4], 30, word_t'($urandom));
    send(1'b0, pool[4], 31, word_t'($urandom));
    send(1'b0, pool[4], ATTR_LIFE, 32'sd2);
    send(1'b1, pool[4], 31, word_t'($urandom));

    while (sent < ITEM_TARGET) begin
      quiet = (sent >= 400 && sent < 650);
      if (!paused && sent >= 800) begin
        // Hold the command channel until every pending quad has drained.
        paused = 1;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      r = $urandom_range(99);
      if (r < 50) begin
        send(1'b1, pool[$urandom_range(POOL - 1)], $urandom_range(31), word_t'($urandom));
      end else if (r < 70) begin
        send(1'b0, pool[$urandom_range(POOL - 1)], $urandom_range(ATTR_X, ATTR_AA),
             rnd_val());
      end else if (r < 80) begin
        send(1'b0, pool[$urandom_range(POOL - 1)], ATTR_LIFE, rnd_life());
      end else if (r < 84) begin
        send(1'b0, pool[$urandom_range(POOL - 1)], ATTR_TRAIL,
             $urandom_range(1) ? word_t'($urandom) : 32'sd0);
      end else if (r < 86) begin
        load_slot(pool[$urandom_range(POOL - 1)]);
      end else if (r < 92) begin
        send(1'b0, $urandom_range(1023), $urandom_range(ATTR_X, 31), word_t'($urandom));
      end else if (r < 96) begin
        send(1'b1, $urandom_range(1023), $urandom_range(31), word_t'($urandom));
      end else begin
        send(1'b0, $urandom_range(1023), ATTR_LIFE, -word_t'($urandom_range(32'h7FFF_FFFF)));
      end
    end
    quiet = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
